[rtl/core/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held (reset is active low).
`define YAY0_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define YAY0_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/yay0_pkg.sv]
// Shared constants, beat types and memory request type for the Yay0 decoder.
`default_nettype none

package yay0_pkg;

    // History window and result packing
    localparam int WINDOW_DEPTH     = 4096;
    localparam int WIN_AW           = $clog2(WINDOW_DEPTH);
    localparam int BYTES_PER_RESULT = 8;
    localparam int CNT_W            = 4;

    // Field widths
    localparam int LEN_W  = 27;
    localparam int DIST_W = 12;
    localparam int RUN_W  = 9;
    localparam int PAIR_W = 16;

    // Run length bases
    localparam int LONG_RUN_BASE  = 18;
    localparam int SHORT_RUN_BASE = 2;

    // Token kinds
    localparam logic MODE_LITERAL = 1'b0;
    localparam logic MODE_BACKREF = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [7:0]          stream_byte;
        logic [PAIR_W-1:0]   ref_pair;
    } t_in_item;

    typedef struct packed {
        logic [63:0]         out_bytes;
        logic [CNT_W-1:0]    byte_count;
        logic                token_end;
        logic                job_done;
        logic                ref_error;
    } t_out_item;

    // Window access from the sequencer: one write and one read per cycle
    typedef struct packed {
        logic                we;
        logic [WIN_AW-1:0]   waddr;
        logic [7:0]          wdata;
        logic [WIN_AW-1:0]   raddr;
    } t_mem_req;

endpackage

`default_nettype wire

[rtl/core/yay0_window_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module yay0_window_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/yay0_ctrl.sv]
// Token sequencer: literal store, back-reference copy loop and result packing.
`default_nettype none

`include "assert_macros.svh"

module yay0_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // token input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire yay0_pkg::t_in_item                i_in_item,
    // output length register
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [yay0_pkg::LEN_W-1:0]        i_cfg_data,
    // window memory
    output yay0_pkg::t_mem_req                     o_mem,
    input  wire logic [7:0]                        i_mem_rdata,
    // result hand-off to the output register
    input  wire logic                              i_slot_free,
    output logic                                   o_push,
    output yay0_pkg::t_out_item                    o_push_item
);

    localparam int AW    = yay0_pkg::WIN_AW;
    localparam int LW    = yay0_pkg::LEN_W;
    localparam int RW    = yay0_pkg::RUN_W;
    localparam int CW    = yay0_pkg::CNT_W;
    localparam int NB    = yay0_pkg::BYTES_PER_RESULT;
    localparam int PW    = 8 * NB;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_HOLD
    } t_state;

    t_state                r_state,     n_state;
    logic [LW-1:0]         r_bw,        n_bw;
    logic [LW-1:0]         r_owed,      n_owed;
    logic                  r_halted,    n_halted;
    logic [AW-1:0]         r_src,       n_src;
    logic [RW-1:0]         r_left,      n_left;
    logic [CW-1:0]         r_iss,       n_iss;
    logic                  r_b_valid,   n_b_valid;
    logic                  r_b_end_chk, n_b_end_chk;
    logic                  r_b_end_run, n_b_end_run;
    logic                  r_fwd,       n_fwd;
    logic [7:0]            r_fwd_data,  n_fwd_data;
    logic [PW-1:0]         r_pack,      n_pack;
    logic [CW-1:0]         r_k,         n_k;
    yay0_pkg::t_out_item   r_res,       n_res;

    logic                  w_accept;
    logic                  w_cfg;
    logic                  w_live;
    logic [7:0]            w_byte;
    logic [PW-1:0]         w_pack_new;
    logic [3:0]            w_field;
    logic [yay0_pkg::DIST_W-1:0] w_dist;
    logic [RW-1:0]         w_run_raw;
    logic [RW-1:0]         w_run;
    logic                  w_ref_err;
    logic [LW-1:0]         w_src_full;
    logic                  w_issue;

    // Handshakes; a pending length write holds tokens off
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_live      = !r_halted && (r_owed != '0);

    // Returning window byte, forwarded when it was written as it was read
    assign w_byte = r_fwd ? r_fwd_data : i_mem_rdata;

    // Drop the returning byte into its lane
    always_comb begin
        w_pack_new = r_pack;
        for (int j = 0; j < NB; j++) begin
            if (r_k == CW'(j)) begin
                w_pack_new[8*j +: 8] = w_byte;
            end
        end
    end

    // Back-reference decode
    assign w_field   = i_in_item.ref_pair[15:12];
    assign w_dist    = i_in_item.ref_pair[yay0_pkg::DIST_W-1:0];
    assign w_run_raw = (w_field == 4'd0)
                     ? RW'(i_in_item.stream_byte) + RW'(yay0_pkg::LONG_RUN_BASE)
                     : RW'(w_field) + RW'(yay0_pkg::SHORT_RUN_BASE);
    assign w_run      = (LW'(w_run_raw) > r_owed) ? r_owed[RW-1:0] : w_run_raw;
    assign w_ref_err  = (LW'(w_dist) >= r_bw);
    assign w_src_full = r_bw - LW'(w_dist) - LW'(1);

    // Read issue: up to one chunk of bytes per pass
    assign w_issue = (r_state == ST_COPY) && (r_left != '0) && (r_iss != CW'(NB));

    // Window port
    always_comb begin
        o_mem.we    = r_b_valid
                   || (w_accept && w_live && i_in_item.mode == yay0_pkg::MODE_LITERAL);
        o_mem.waddr = r_bw[AW-1:0];
        o_mem.wdata = r_b_valid ? w_byte : i_in_item.stream_byte;
        o_mem.raddr = r_src;
    end

    assign o_push      = (r_state == ST_HOLD) && i_slot_free;
    assign o_push_item = r_res;

    // Next state
    always_comb begin
        n_state     = r_state;
        n_bw        = r_bw;
        n_owed      = r_owed;
        n_halted    = r_halted;
        n_src       = r_src;
        n_left      = r_left;
        n_iss       = r_iss;
        n_b_valid   = 1'b0;
        n_b_end_chk = r_b_end_chk;
        n_b_end_run = r_b_end_run;
        n_fwd       = r_b_valid && (r_src == r_bw[AW-1:0]);
        n_fwd_data  = w_byte;
        n_pack      = r_pack;
        n_k         = r_k;
        n_res       = r_res;

        case (r_state)
            ST_IDLE: begin
                if (w_cfg) begin
                    n_owed   = i_cfg_data;
                    n_bw     = '0;
                    n_halted = 1'b0;
                end else if (w_accept && w_live) begin
                    if (i_in_item.mode == yay0_pkg::MODE_LITERAL) begin
                        n_bw             = r_bw + LW'(1);
                        n_owed           = r_owed - LW'(1);
                        n_res.out_bytes  = 64'(i_in_item.stream_byte);
                        n_res.byte_count = CW'(1);
                        n_res.token_end  = 1'b1;
                        n_res.job_done   = (r_owed == LW'(1));
                        n_res.ref_error  = 1'b0;
                        n_state          = ST_HOLD;
                    end else if (w_ref_err) begin
                        n_halted         = 1'b1;
                        n_res.out_bytes  = '0;
                        n_res.byte_count = '0;
                        n_res.token_end  = 1'b1;
                        n_res.job_done   = 1'b0;
                        n_res.ref_error  = 1'b1;
                        n_state          = ST_HOLD;
                    end else begin
                        n_src   = w_src_full[AW-1:0];
                        n_left  = w_run;
                        n_iss   = '0;
                        n_k     = '0;
                        n_pack  = '0;
                        n_state = ST_COPY;
                    end
                end
            end

            ST_COPY: begin
                // issue side
                if (w_issue) begin
                    n_b_valid   = 1'b1;
                    n_b_end_chk = (r_iss == CW'(NB - 1)) || (r_left == RW'(1));
                    n_b_end_run = (r_left == RW'(1));
                    n_src       = r_src + AW'(1);
                    n_left      = r_left - RW'(1);
                    n_iss       = r_iss + CW'(1);
                end
                // write-back side
                if (r_b_valid) begin
                    n_bw   = r_bw + LW'(1);
                    n_owed = r_owed - LW'(1);
                    n_pack = w_pack_new;
                    n_k    = r_k + CW'(1);
                    if (r_b_end_chk) begin
                        n_res.out_bytes  = 64'(w_pack_new);
                        n_res.byte_count = r_k + CW'(1);
                        n_res.token_end  = r_b_end_run;
                        n_res.job_done   = (r_owed == LW'(1));
                        n_res.ref_error  = 1'b0;
                        n_state          = ST_HOLD;
                    end
                end
            end

            ST_HOLD: begin
                if (i_slot_free) begin
                    n_iss   = '0;
                    n_k     = '0;
                    n_pack  = '0;
                    n_state = r_res.token_end ? ST_IDLE : ST_COPY;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bw      <= '0;
            r_owed    <= '0;
            r_halted  <= 1'b0;
            r_b_valid <= 1'b0;
            r_iss     <= '0;
            r_k       <= '0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_bw      <= n_bw;
            r_owed    <= n_owed;
            r_halted  <= n_halted;
            r_b_valid <= n_b_valid;
            r_iss     <= n_iss;
            r_k       <= n_k;
            r_left    <= n_left;
        end
        r_src       <= n_src;
        r_b_end_chk <= n_b_end_chk;
        r_b_end_run <= n_b_end_run;
        r_fwd       <= n_fwd;
        r_fwd_data  <= n_fwd_data;
        r_pack      <= n_pack;
        r_res       <= n_res;
    end

    // Checks
    `YAY0_ASSERT(a_wb_owed, i_clk, i_rst_n, r_b_valid |-> (r_owed != '0),
                 "copy wrote a byte past the job length")
    `YAY0_ASSERT(a_wb_in_copy, i_clk, i_rst_n, r_b_valid |-> (r_state == ST_COPY),
                 "window write-back outside the copy loop")
    `YAY0_ASSERT(a_err_empty, i_clk, i_rst_n,
                 (r_state == ST_HOLD && r_res.ref_error) |-> (r_res.byte_count == '0 && r_halted),
                 "error result carries bytes or block not halted")
    `YAY0_ASSERT(a_chunk_fill, i_clk, i_rst_n, r_iss <= CW'(NB),
                 "chunk issued more reads than a result holds")

endmodule

`default_nettype wire

[rtl/core/yay0_lz_decompressor.sv]
// A literal is held in the sequencer's result register, then in the output register.
// Tokens are taken one at a time; a back-reference is copied by the window read loop,
// one byte per cycle while it is not waiting to hand a result to the output register.
// Output stalls hold the loop back; the output register frees the loop early.
// Reset: synchronous, active low; clears control state and the length register.
// The history window is not cleared and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module yay0_lz_decompressor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // token input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire yay0_pkg::t_in_item             i_in_item,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output yay0_pkg::t_out_item                 o_out_item,
    // output length register
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [yay0_pkg::LEN_W-1:0]     i_cfg_data
);

    yay0_pkg::t_mem_req    w_mem;
    logic [7:0]            w_rdata;
    logic                  w_slot_free;
    logic                  w_push;
    yay0_pkg::t_out_item   w_push_item;

    logic                  r_out_valid;
    yay0_pkg::t_out_item   r_out;

    // Sequencer
    yay0_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (w_mem),
        .i_mem_rdata (w_rdata),
        .i_slot_free (w_slot_free),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    // History window
    yay0_window_ram #(
        .DEPTH (yay0_pkg::WINDOW_DEPTH),
        .WIDTH (8)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Output register: takes a new beat when empty or being drained
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_push) begin
            r_out <= w_push_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    `YAY0_ASSERT(a_push_free, i_clk, i_rst_n, w_push |-> w_slot_free,
                 "result pushed into an occupied output register")
    `YAY0_ASSERT(a_out_count, i_clk, i_rst_n,
                 r_out_valid |-> (r_out.byte_count <= 4'(yay0_pkg::BYTES_PER_RESULT)),
                 "output beat claims too many bytes")
    `YAY0_ASSERT(a_err_end, i_clk, i_rst_n,
                 (r_out_valid && r_out.ref_error) |-> (r_out.token_end && !r_out.job_done),
                 "error beat not marked as token end")
    `YAY0_ASSERT_ALWAYS(a_rst_empty, i_clk, $past(!i_rst_n) |-> !r_out_valid,
                        "output register holds a beat after reset")

endmodule

`default_nettype wire

[verif/yay0_stream_checker.sv]
// Checker for the Yay0 decoder: predicts every result beat and compares it.
`timescale 1ns / 1ps

module yay0_stream_checker
    import yay0_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    // Predicted decoder state
    logic [7:0]       history [WINDOW_DEPTH];
    logic [LEN_W-1:0] job_len  = '0;
    logic [LEN_W-1:0] produced = '0;
    bit               halted   = 1'b0;

    // Beats still owed by the block, oldest first
    t_out_item        predicted_beats [$];
    int               fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fails++;
    endtask

    function automatic void store_byte(input logic [7:0] b);
        history[produced[WIN_AW-1:0]] = b;
        produced = produced + 1'b1;
    endfunction

    function automatic void push_beat(input logic [63:0] bytes, input logic [CNT_W-1:0] cnt,
                                      input logic last, input logic err);
        t_out_item beat;
        beat.out_bytes  = bytes;
        beat.byte_count = cnt;
        beat.token_end  = last;
        beat.job_done   = !err && (produced >= job_len);
        beat.ref_error  = err;
        predicted_beats.push_back(beat);
    endfunction

    // Expand one token into the beats it should produce
    function automatic void expand_token(input t_in_item tok);
        int unsigned owed;
        int unsigned run;
        int unsigned back_dist;
        int unsigned src;
        int unsigned k;
        logic [63:0] pack;
        logic [7:0]  b;
        if (halted || produced >= job_len)
            return;
        owed = job_len - produced;
        if (tok.mode == MODE_LITERAL) begin
            store_byte(tok.stream_byte);
            push_beat({56'd0, tok.stream_byte}, CNT_W'(1), 1'b1, 1'b0);
            return;
        end
        back_dist = tok.ref_pair[DIST_W-1:0];
        if (tok.ref_pair[PAIR_W-1:DIST_W] == '0)
            run = tok.stream_byte + LONG_RUN_BASE;
        else
            run = tok.ref_pair[PAIR_W-1:DIST_W] + SHORT_RUN_BASE;
        if (run > owed)
            run = owed;
        // source before the start of the job: one error beat, then halt
        if (back_dist + 1 > produced) begin
            halted = 1'b1;
            push_beat(64'd0, '0, 1'b1, 1'b1);
            return;
        end
        // byte-wise copy so that overlapping runs repeat data
        src  = produced - back_dist - 1;
        pack = '0;
        k    = 0;
        for (int unsigned i = 0; i < run; i++) begin
            b = history[src % WINDOW_DEPTH];
            src++;
            store_byte(b);
            pack |= 64'(b) << (8 * k);
            k++;
            if (k == BYTES_PER_RESULT || i + 1 == run) begin
                push_beat(pack, CNT_W'(k), i + 1 == run, 1'b0);
                pack = '0;
                k    = 0;
            end
        end
    endfunction

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (predicted_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
            return;
        end
        want = predicted_beats.pop_front();
        if (got.out_bytes !== want.out_bytes)
            report_mismatch($sformatf("out_bytes %h, want %h", got.out_bytes, want.out_bytes));
        if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("byte_count %0d, want %0d",
                                      got.byte_count, want.byte_count));
        if (got.token_end !== want.token_end)
            report_mismatch($sformatf("token_end %b, want %b", got.token_end, want.token_end));
        if (got.job_done !== want.job_done)
            report_mismatch($sformatf("job_done %b, want %b", got.job_done, want.job_done));
        if (got.ref_error !== want.ref_error)
            report_mismatch($sformatf("ref_error %b, want %b", got.ref_error, want.ref_error));
    endtask

    // Watch all three channels; outputs first, then the new token
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            job_len  = '0;
            produced = '0;
            halted   = 1'b0;
            predicted_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_beat(i_out_item);
            if (i_cfg_valid && i_cfg_ready) begin
                job_len  = i_cfg_data;
                produced = '0;
                halted   = 1'b0;
            end
            if (i_in_valid && !i_in_stall)
                expand_token(i_in_item);
        end
        o_pending <= predicted_beats.size();
    end

endmodule

[verif/tb_yay0_lz_decompressor.sv]
// Testbench top for the Yay0 decoder: token stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_yay0_lz_decompressor;
    import yay0_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_TOKENS  = 150;
    localparam int MAX_LEN       = 67108864;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             tok_valid  = 1'b0;
    logic             tok_stall;
    t_in_item         tok_item   = '0;
    logic             beat_valid;
    logic             beat_stall = 1'b0;
    t_out_item        beat_item;
    logic             len_valid  = 1'b0;
    logic             len_ready;
    logic [LEN_W-1:0] len_data   = '0;
    int               fail_count;
    int               pending;

    // Stimulus-side view of the running job, used to aim back-references
    int unsigned      job_pos     = 0;
    int unsigned      job_size    = 0;
    bit               job_over    = 1'b1;
    int               tokens_sent = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               hold_toggle = 1'b0;
    bit               hold_seen   = 1'b0;
    int               hold_left   = 0;
    int               quiet_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    yay0_lz_decompressor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tok_valid),
        .o_in_stall  (tok_stall),
        .i_in_item   (tok_item),
        .o_out_valid (beat_valid),
        .i_out_stall (beat_stall),
        .o_out_item  (beat_item),
        .i_cfg_valid (len_valid),
        .o_cfg_ready (len_ready),
        .i_cfg_data  (len_data)
    );

    yay0_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (tok_valid),
        .i_in_stall   (tok_stall),
        .i_in_item    (tok_item),
        .i_out_valid  (beat_valid),
        .i_out_stall  (beat_stall),
        .i_out_item   (beat_item),
        .i_cfg_valid  (len_valid),
        .i_cfg_ready  (len_ready),
        .i_cfg_data   (len_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off when the toggle flips
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            hold_left  <= HOLD_CYCLES;
            beat_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            beat_stall <= 1'b1;
        end else begin
            beat_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: too long without any beat on any channel
    always @(posedge clk) begin
        if (!rst_n || (tok_valid && !tok_stall) || (beat_valid && !beat_stall)
                || (len_valid && len_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_yay0_lz_decompressor: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item token_of(input logic mode, input logic [7:0] sb,
                                          input logic [PAIR_W-1:0] pair);
        t_in_item tok;
        tok.mode        = mode;
        tok.stream_byte = sb;
        tok.ref_pair    = pair;
        return tok;
    endfunction

    // Offer one token, with random gaps, and follow the job's progress
    task automatic send_token(input t_in_item tok);
        int unsigned run;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            tok_valid <= 1'b0;
            @(posedge clk);
        end
        tok_valid <= 1'b1;
        tok_item  <= tok;
        @(posedge clk);
        while (tok_stall)
            @(posedge clk);
        if (!job_over) begin
            tokens_sent++;
            if (tok.mode == MODE_LITERAL) begin
                job_pos++;
            end else if (tok.ref_pair[DIST_W-1:0] + 1 > job_pos) begin
                job_over = 1'b1;
            end else begin
                if (tok.ref_pair[PAIR_W-1:DIST_W] == '0)
                    run = tok.stream_byte + LONG_RUN_BASE;
                else
                    run = tok.ref_pair[PAIR_W-1:DIST_W] + SHORT_RUN_BASE;
                job_pos += (run < job_size - job_pos) ? run : job_size - job_pos;
            end
            if (job_pos >= job_size)
                job_over = 1'b1;
        end
    endtask

    // Stop offering and wait for every predicted beat, then let the block settle
    task automatic wait_drained(input int settle);
        tok_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Length write once the block is idle; starts a new job
    task automatic new_job(input int unsigned len);
        wait_drained(SETTLE_CYCLES);
        len_valid <= 1'b1;
        len_data  <= LEN_W'(len);
        @(posedge clk);
        while (!len_ready)
            @(posedge clk);
        len_valid <= 1'b0;
        job_size = len;
        job_pos  = 0;
        job_over = (len == 0);
    endtask

    // Mostly well-formed tokens: literals and in-range references, some noise
    function automatic t_in_item make_token(input int zero_field_pct);
        t_in_item    tok;
        int unsigned reach;
        int          roll;
        tok.mode        = MODE_LITERAL;
        tok.stream_byte = 8'($urandom_range(0, 255));
        tok.ref_pair    = PAIR_W'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (job_pos == 0) begin
            if (roll < 8)
                tok.mode = MODE_BACKREF;
            return tok;
        end
        if (roll < 40)
            return tok;
        tok.mode = MODE_BACKREF;
        if (roll >= 95)
            return tok;
        reach = (job_pos < WINDOW_DEPTH) ? job_pos : WINDOW_DEPTH;
        if ($urandom_range(0, 1) == 0)
            tok.ref_pair[DIST_W-1:0] = DIST_W'($urandom_range(0, (reach > 16) ? 15 : reach - 1));
        else
            tok.ref_pair[DIST_W-1:0] = DIST_W'($urandom_range(0, reach - 1));
        if ($urandom_range(0, 99) < zero_field_pct)
            tok.ref_pair[PAIR_W-1:DIST_W] = '0;
        else if (tok.ref_pair[PAIR_W-1:DIST_W] == '0)
            tok.ref_pair[PAIR_W-1:DIST_W] = 4'($urandom_range(1, 15));
        return tok;
    endfunction

    task automatic run_job(input int unsigned len, input int zero_field_pct,
                           input int max_tokens, input int pause_at, input int squeeze_at);
        int n;
        new_job(len);
        n = 0;
        while (!job_over && n < max_tokens) begin
            if (n == pause_at)
                wait_drained(0);
            if (n == squeeze_at)
                hold_toggle <= ~hold_toggle;
            send_token(make_token(zero_field_pct));
            n++;
        end
        // sometimes one more token; if the job has ended, the block drops it
        if ($urandom_range(0, 3) == 0)
            send_token(make_token(zero_field_pct));
    endtask

    initial begin
        int phase_start;
        int roll;
        bit first;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero length: job counts as finished, token dropped
        new_job('0);
        send_token(token_of(MODE_LITERAL, 8'h5A, 16'h0000));

        // field extremes, overlapping runs, long run clamped to what is owed
        new_job(64);
        send_token(token_of(MODE_LITERAL, 8'h00, 16'hFFFF));
        send_token(token_of(MODE_LITERAL, 8'hFF, 16'h0000));
        send_token(token_of(MODE_LITERAL, 8'hA5, 16'h5A5A));
        send_token(token_of(MODE_BACKREF, 8'h00, 16'h1000));
        send_token(token_of(MODE_BACKREF, 8'h00, 16'h0002));
        send_token(token_of(MODE_BACKREF, 8'hFF, 16'hF005));
        send_token(token_of(MODE_BACKREF, 8'hFF, 16'h0028));
        send_token(token_of(MODE_LITERAL, 8'h11, 16'h0000));

        // reference before the start on the very first token, then halted
        new_job(6);
        send_token(token_of(MODE_BACKREF, 8'h00, 16'h0000));
        send_token(token_of(MODE_LITERAL, 8'h22, 16'h0000));

        // farthest distance from too short a history
        new_job(5);
        send_token(token_of(MODE_LITERAL, 8'h80, 16'h0000));
        send_token(token_of(MODE_BACKREF, 8'hFF, 16'hFFFF));

        // one-byte job
        new_job(1);
        send_token(token_of(MODE_LITERAL, 8'h7F, 16'h0000));

        // large length of 2**26; the 27-bit field holds up to 2**27 - 1
        new_job(MAX_LEN);
        send_token(token_of(MODE_LITERAL, 8'h01, 16'h0000));
        send_token(token_of(MODE_BACKREF, 8'h00, 16'h2000));
        send_token(token_of(MODE_BACKREF, 8'h3C, 16'h0FFF));

        // random jobs under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained(SETTLE_CYCLES);
            send_idle_pct =  (ph == 0) ? 32 : (ph == 1) ? 75 : 0;
            recv_idle_pct <= (ph == 0) ? 75 : (ph == 1) ? 32 : 0;
            phase_start = tokens_sent;
            first = 1'b1;
            while (tokens_sent - phase_start < PHASE_TOKENS) begin
                roll = $urandom_range(0, 9);
                if (first)
                    run_job(6000, 60, 120, (ph == 0) ? 10 : -1, (ph == 2) ? 5 : -1);
                else if (roll < 6)
                    run_job($urandom_range(16, 200), 25, 60, -1, -1);
                else if (roll < 9)
                    run_job($urandom_range(200, 1500), 25, 60, -1, -1);
                else
                    run_job($urandom_range(1, 15), 25, 60, -1, -1);
                first = 1'b0;
            end
        end

        wait_drained(32);
        if (fail_count == 0)
            $display("tb_yay0_lz_decompressor: PASS");
        else
            $display("tb_yay0_lz_decompressor: FAIL");
        $finish;
    end

endmodule
